### rtl/itoa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for the decimal text converter
// Powers of ten, digit step table, character codes and the queue entry.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned NUM_POW   = 10;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned MAG_W     = 32;
  localparam int unsigned STEP_W    = 34;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] TERM_RESET = 8'd46;

  localparam logic [MAG_W-1:0] POW10 [0:NUM_POW-1] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  typedef logic [9:1][STEP_W-1:0] step_row_t;
  typedef step_row_t [NUM_POW-1:0] step_tbl_t;

  // k * 10^i for every digit position and nonzero digit
  function automatic step_tbl_t build_step_tbl();
    step_tbl_t tbl;
    tbl = '0;
    for (int i = 0; i < NUM_POW; i++) begin
      for (int k = 1; k <= 9; k++) begin
        tbl[i][k] = STEP_W'(64'(k) * 64'(POW10[i]));
      end
    end
    return tbl;
  endfunction

  localparam step_tbl_t STEP_TBL = build_step_tbl();

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [IDX_W-1:0] top_idx;
  } itoa_entry_t;

endpackage
`default_nettype wire

### rtl/itoa_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_front: request intake and classification
// Split a signed value into sign, magnitude and leading digit position.
// ----------------------------------------------------------------------------
module itoa_front (
  input  wire logic [31:0]          value,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 q_full,
  output logic                      push,
  output itoa_pkg::itoa_entry_t     push_entry
);
  import itoa_pkg::*;

  logic signed [MAG_W:0] wide;
  logic [IDX_W-1:0]      top;
  logic                  hit;
  logic signed [MAG_W:0] pos_th;
  logic signed [MAG_W:0] neg_th;

  assign wide = {value[MAG_W-1], value};

  // Highest power of ten not above the magnitude, compared on the raw value
  always_comb begin
    top    = '0;
    hit    = 1'b0;
    pos_th = '0;
    neg_th = '0;
    for (int k = 1; k < NUM_POW; k++) begin
      pos_th = $signed({1'b0, POW10[k]});
      neg_th = -pos_th;
      hit    = value[MAG_W-1] ? (wide <= neg_th) : (wide >= pos_th);
      if (hit) begin
        top = IDX_W'(k);
      end
    end
  end

  assign in_ready   = !q_full;
  assign push       = in_valid && !q_full;
  assign push_entry = '{neg:     value[MAG_W-1],
                        mag:     value[MAG_W-1] ? (MAG_W'(0) - value) : value,
                        top_idx: top};

endmodule
`default_nettype wire

### rtl/itoa_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_queue: short queue between intake and digit generation
// Two-entry FIFO of classified requests.
// ----------------------------------------------------------------------------
module itoa_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire itoa_pkg::itoa_entry_t push_entry,
  input  wire logic                 pop,
  output itoa_pkg::itoa_entry_t     head,
  output logic                      full,
  output logic                      empty
);
  import itoa_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  itoa_entry_t        entries [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full  = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/itoa_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_back: character generator
// Emit sign if negative, one digit per cycle unless stalled, then terminator.
// ----------------------------------------------------------------------------
module itoa_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire itoa_pkg::itoa_entry_t head,
  input  wire logic                  q_empty,
  output logic                       pop,
  input  wire logic [7:0]            terminator,
  output logic [7:0]                 char_code,
  output logic                       last,
  output logic                       out_valid,
  input  wire logic                  out_ready
);
  import itoa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_TERM
  } state_t;

  state_t             state;
  logic [MAG_W-1:0]   rem;
  logic [IDX_W-1:0]   idx;
  logic               can_load;
  logic               emit;
  logic [3:0]         digit;
  logic [MAG_W-1:0]   rem_next;
  logic [STEP_W:0]    diff [1:9];

  assign can_load = !out_valid || out_ready;
  assign pop      = (state == ST_IDLE) && !q_empty && can_load;
  // a new character enters the output register this cycle
  assign emit     = can_load && (((state == ST_IDLE) && !q_empty && head.neg) ||
                                 (state == ST_DIGIT) || (state == ST_TERM));

  // Try every digit in parallel, keep the largest that does not underflow
  always_comb begin
    digit    = '0;
    rem_next = rem;
    for (int k = 1; k <= 9; k++) begin
      diff[k] = {3'b000, rem} - {1'b0, STEP_TBL[idx][k]};
      if (!diff[k][STEP_W]) begin
        digit    = 4'(k);
        rem_next = diff[k][MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            rem   <= head.mag;
            idx   <= head.top_idx;
            state <= ST_DIGIT;
            if (head.neg) begin
              char_code <= CHAR_MINUS;
              last      <= 1'b0;
            end
          end
        end
        ST_DIGIT: begin
          if (can_load) begin
            char_code <= CHAR_ZERO + {4'b0000, digit};
            last      <= 1'b0;
            rem       <= rem_next;
            if (idx == '0) begin
              state <= ST_TERM;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        ST_TERM: begin
          if (can_load) begin
            char_code <= terminator;
            last      <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/signed_int_to_decimal_ascii.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Each request carries one value; the block answers with its decimal text,
// most significant digit first, led by '-' when negative, closed by the
// terminator character with last set.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  input   | in_valid / in_ready   | value[31:0] signed
//  output  | out_valid / out_ready | char_code[7:0], last
//  config  | cfg_valid / cfg_ready | cfg_data[7:0] terminator code
//
//  For each value the character generator pulls it from the queue, sending
//  the sign at that point when negative, then sends its digits and the
//  terminator; one digit per cycle while the output is not stalled comes
//  from a parallel subtract-and-select against the table of digit multiples.
//  Reset is synchronous and restores the terminator to '.'.
//  The intake keeps taking requests into a two-entry queue until it is full
//  while output stalls; a held output character freezes only the generator.
//
module signed_int_to_decimal_ascii (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] value,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic [7:0]       char_code,
  output logic             last,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready
);
  import itoa_pkg::*;

  logic        [7:0] terminator;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  itoa_entry_t       push_entry;
  itoa_entry_t       head;

  // Terminator register: always ready; write it only while no request is in
  // flight, since the generator reads it when it sends the terminator
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      terminator <= TERM_RESET;
    end else if (cfg_valid) begin
      terminator <= cfg_data;
    end
  end

  // Intake: classify sign, magnitude and leading digit position
  itoa_front u_front (
    .value      (value),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Hold classified requests so intake and output stall independently
  itoa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // Generate the characters into the output register
  itoa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .terminator (terminator),
    .char_code  (char_code),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule
`default_nettype wire
